// ===== design/onewire_master_slot_engine_macros.svh =====
// Assertion macros shared by the One-Wire master slot engine.
`ifndef ONEWIRE_MASTER_SLOT_ENGINE_MACROS_SVH
`define ONEWIRE_MASTER_SLOT_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("onewire engine check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("onewire engine check failed");

`endif

// ===== design/owm_pkg.sv =====
// Types and constants shared by the One-Wire master slot engine.
`timescale 1ns / 1ps

package owm_pkg;

  // Fixed release times after the low part of a write slot.
  localparam logic [9:0] WR1_RECOVERY = 10'd58;
  localparam logic [9:0] WR0_RECOVERY = 10'd2;

  // Configuration address width: eight registers at four-byte spacing.
  localparam int unsigned AddrWidth = 5;

  // Reset values of the configuration registers.
  localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd750;
  localparam logic [7:0] RESET_RELEASE_DEFAULT = 8'd15;
  localparam logic [7:0] PRES_WAIT_DEFAULT     = 8'd100;
  localparam logic [8:0] PRES_LOW_DEFAULT      = 9'd240;
  localparam logic [3:0] ONE_LOW_DEFAULT       = 4'd8;
  localparam logic [6:0] ZERO_LOW_DEFAULT      = 7'd70;
  localparam logic [3:0] READ_LOW_DEFAULT      = 4'd10;
  localparam logic [6:0] READ_TAIL_DEFAULT     = 7'd45;

  // Command codes carried with each tick item.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_RESET_RELEASE = 3'd1,
    REG_PRES_WAIT     = 3'd2,
    REG_PRES_LOW      = 3'd3,
    REG_ONE_LOW       = 3'd4,
    REG_ZERO_LOW      = 3'd5,
    REG_READ_LOW      = 3'd6,
    REG_READ_TAIL     = 3'd7
  } reg_e;

  // Sequencer phases, one-hot.
  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_RST_LOW   = 10'b00_0000_0010,
    PH_RST_REL   = 10'b00_0000_0100,
    PH_PRES_WAIT = 10'b00_0000_1000,
    PH_PRES_LOW  = 10'b00_0001_0000,
    PH_WR_LOW    = 10'b00_0010_0000,
    PH_WR_REC    = 10'b00_0100_0000,
    PH_RD_LOW    = 10'b00_1000_0000,
    PH_RD_SAMP   = 10'b01_0000_0000,
    PH_RD_TAIL   = 10'b10_0000_0000
  } phase_e;

  // Timing configuration as seen by the sequencer.
  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] reset_release_time;
    logic [7:0] presence_wait_limit;
    logic [8:0] presence_low_limit;
    logic [3:0] one_low_time;
    logic [6:0] zero_low_time;
    logic [3:0] read_low_time;
    logic [6:0] read_tail_time;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       no_device;
    logic [7:0] rx_byte;
  } result_t;

endpackage

// ===== design/owm_regs.sv =====
// APB configuration registers of the One-Wire master slot engine.
`timescale 1ns / 1ps

module owm_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [owm_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output owm_pkg::cfg_t                  cfg_o
);

  owm_pkg::cfg_t cfg_q;
  owm_pkg::reg_e reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = owm_pkg::reg_e'(paddr[owm_pkg::AddrWidth-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time      <= owm_pkg::RESET_LOW_DEFAULT;
      cfg_q.reset_release_time  <= owm_pkg::RESET_RELEASE_DEFAULT;
      cfg_q.presence_wait_limit <= owm_pkg::PRES_WAIT_DEFAULT;
      cfg_q.presence_low_limit  <= owm_pkg::PRES_LOW_DEFAULT;
      cfg_q.one_low_time        <= owm_pkg::ONE_LOW_DEFAULT;
      cfg_q.zero_low_time       <= owm_pkg::ZERO_LOW_DEFAULT;
      cfg_q.read_low_time       <= owm_pkg::READ_LOW_DEFAULT;
      cfg_q.read_tail_time      <= owm_pkg::READ_TAIL_DEFAULT;
    end else if (wr_en) begin
      unique case (reg_idx)
        owm_pkg::REG_RESET_LOW:     cfg_q.reset_low_time      <= pwdata[9:0];
        owm_pkg::REG_RESET_RELEASE: cfg_q.reset_release_time  <= pwdata[7:0];
        owm_pkg::REG_PRES_WAIT:     cfg_q.presence_wait_limit <= pwdata[7:0];
        owm_pkg::REG_PRES_LOW:      cfg_q.presence_low_limit  <= pwdata[8:0];
        owm_pkg::REG_ONE_LOW:       cfg_q.one_low_time        <= pwdata[3:0];
        owm_pkg::REG_ZERO_LOW:      cfg_q.zero_low_time       <= pwdata[6:0];
        owm_pkg::REG_READ_LOW:      cfg_q.read_low_time       <= pwdata[3:0];
        owm_pkg::REG_READ_TAIL:     cfg_q.read_tail_time      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read-back mux, zero-extended to the bus width.
  always_comb begin
    unique case (reg_idx)
      owm_pkg::REG_RESET_LOW:     prdata = {22'd0, cfg_q.reset_low_time};
      owm_pkg::REG_RESET_RELEASE: prdata = {24'd0, cfg_q.reset_release_time};
      owm_pkg::REG_PRES_WAIT:     prdata = {24'd0, cfg_q.presence_wait_limit};
      owm_pkg::REG_PRES_LOW:      prdata = {23'd0, cfg_q.presence_low_limit};
      owm_pkg::REG_ONE_LOW:       prdata = {28'd0, cfg_q.one_low_time};
      owm_pkg::REG_ZERO_LOW:      prdata = {25'd0, cfg_q.zero_low_time};
      owm_pkg::REG_READ_LOW:      prdata = {28'd0, cfg_q.read_low_time};
      owm_pkg::REG_READ_TAIL:     prdata = {25'd0, cfg_q.read_tail_time};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/owm_core.sv =====
// Slot sequencer: bus state and the per-tick update of the One-Wire master.
`timescale 1ns / 1ps

module owm_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       tx_byte_i,
  input  logic             line_level_i,
  input  owm_pkg::cfg_t    cfg_i,
  output owm_pkg::result_t res_o
);

  owm_pkg::phase_e phase_q, phase_d;
  logic [9:0]      tick_count_q, tick_count_d;
  logic [2:0]      bit_index_q, bit_index_d;
  logic [7:0]      shift_byte_q, shift_byte_d;
  logic            presence_q, presence_d;
  logic [7:0]      rx_q, rx_d;

  owm_pkg::cmd_e   cmd;
  logic [9:0]      tick_inc;
  logic [9:0]      slot_len;
  logic [9:0]      rec_len;
  logic            drive;
  logic            done;

  assign cmd = owm_pkg::cmd_e'(cmd_i);

  // Next state for one tick: command start first, then the phase step.
  always_comb begin
    phase_d      = phase_q;
    tick_count_d = tick_count_q;
    bit_index_d  = bit_index_q;
    shift_byte_d = shift_byte_q;
    presence_d   = presence_q;
    rx_d         = rx_q;
    drive        = 1'b0;
    done         = 1'b0;

    if (phase_q == owm_pkg::PH_IDLE && cmd != owm_pkg::CMD_TICK) begin
      tick_count_d = 10'd0;
      bit_index_d  = 3'd0;
      case (cmd)
        owm_pkg::CMD_RESET: phase_d = owm_pkg::PH_RST_LOW;
        owm_pkg::CMD_WRITE: begin
          shift_byte_d = tx_byte_i;
          phase_d      = owm_pkg::PH_WR_LOW;
        end
        default: begin
          shift_byte_d = 8'd0;
          phase_d      = owm_pkg::PH_RD_LOW;
        end
      endcase
    end

    tick_inc = tick_count_d + 10'd1;
    slot_len = shift_byte_d[0] ? {6'd0, cfg_i.one_low_time} : {3'd0, cfg_i.zero_low_time};
    rec_len  = shift_byte_d[0] ? owm_pkg::WR1_RECOVERY : owm_pkg::WR0_RECOVERY;

    unique case (phase_d)
      owm_pkg::PH_RST_LOW: begin
        drive        = 1'b1;
        tick_count_d = tick_inc;
        if (tick_inc >= cfg_i.reset_low_time) begin
          tick_count_d = 10'd0;
          phase_d = (cfg_i.reset_release_time == 8'd0) ? owm_pkg::PH_PRES_WAIT
                                                         : owm_pkg::PH_RST_REL;
        end
      end
      owm_pkg::PH_RST_REL: begin
        tick_count_d = tick_inc;
        if (tick_inc >= {2'd0, cfg_i.reset_release_time}) begin
          tick_count_d = 10'd0;
          phase_d      = owm_pkg::PH_PRES_WAIT;
        end
      end
      owm_pkg::PH_PRES_WAIT: begin
        if (line_level_i) begin
          tick_count_d = tick_inc;
          if (tick_inc >= {2'd0, cfg_i.presence_wait_limit}) begin
            presence_d = 1'b1;
            done       = 1'b1;
          end
        end else if (cfg_i.presence_low_limit <= 9'd1) begin
          // A low limit of zero or one tick ends the reset on the first low tick.
          presence_d = 1'b1;
          done       = 1'b1;
        end else begin
          tick_count_d = 10'd1;
          phase_d      = owm_pkg::PH_PRES_LOW;
        end
      end
      owm_pkg::PH_PRES_LOW: begin
        if (line_level_i) begin
          presence_d = 1'b0;
          done       = 1'b1;
        end else begin
          tick_count_d = tick_inc;
          if (tick_inc >= {1'd0, cfg_i.presence_low_limit}) begin
            presence_d = 1'b1;
            done       = 1'b1;
          end
        end
      end
      owm_pkg::PH_WR_LOW: begin
        drive        = 1'b1;
        tick_count_d = tick_inc;
        if (tick_inc >= slot_len) begin
          tick_count_d = 10'd0;
          phase_d      = owm_pkg::PH_WR_REC;
        end
      end
      owm_pkg::PH_WR_REC: begin
        tick_count_d = tick_inc;
        if (tick_inc >= rec_len) begin
          tick_count_d = 10'd0;
          shift_byte_d = {1'b0, shift_byte_d[7:1]};
          if (bit_index_d == 3'd7) begin
            done = 1'b1;
          end else begin
            bit_index_d = bit_index_d + 3'd1;
            phase_d     = owm_pkg::PH_WR_LOW;
          end
        end
      end
      owm_pkg::PH_RD_LOW: begin
        drive        = 1'b1;
        tick_count_d = tick_inc;
        if (tick_inc >= {6'd0, cfg_i.read_low_time}) begin
          tick_count_d = 10'd0;
          phase_d      = owm_pkg::PH_RD_SAMP;
        end
      end
      owm_pkg::PH_RD_SAMP: begin
        shift_byte_d = {line_level_i, shift_byte_d[7:1]};
        tick_count_d = 10'd0;
        phase_d      = owm_pkg::PH_RD_TAIL;
      end
      owm_pkg::PH_RD_TAIL: begin
        tick_count_d = tick_inc;
        if (tick_inc >= {3'd0, cfg_i.read_tail_time}) begin
          tick_count_d = 10'd0;
          if (bit_index_d == 3'd7) begin
            rx_d = shift_byte_d;
            done = 1'b1;
          end else begin
            bit_index_d = bit_index_d + 3'd1;
            phase_d     = owm_pkg::PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_d      = owm_pkg::PH_IDLE;
        tick_count_d = 10'd0;
        bit_index_d  = 3'd0;
      end
    endcase

    // Completion returns the sequencer to idle with cleared counters.
    if (done) begin
      phase_d      = owm_pkg::PH_IDLE;
      tick_count_d = 10'd0;
      bit_index_d  = 3'd0;
    end
  end

  // Result of this tick.
  always_comb begin
    res_o.drive_low = drive;
    res_o.busy_res  = (phase_d != owm_pkg::PH_IDLE);
    res_o.done_res  = done;
    res_o.no_device = presence_d;
    res_o.rx_byte   = rx_d;
  end

  // State advances once per processed tick item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= owm_pkg::PH_IDLE;
      tick_count_q <= 10'd0;
      bit_index_q  <= 3'd0;
      shift_byte_q <= 8'd0;
      presence_q   <= 1'b0;
      rx_q         <= 8'd0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      tick_count_q <= tick_count_d;
      bit_index_q  <= bit_index_d;
      shift_byte_q <= shift_byte_d;
      presence_q   <= presence_d;
      rx_q         <= rx_d;
    end
  end

endmodule

// ===== design/onewire_master_slot_engine.sv =====
// Top level of the One-Wire master slot engine: item registers, sequencer and config.
// An accepted tick item waits in the input register, and its result item is offered
// from the output register. Throughput: one tick item per cycle unless the output
// side stalls; input register, one-tick update and output register make a single pass.
// Reset (rst_ni low, asynchronous): both item registers empty, sequencer idle with
// counters, shift byte, no_device and rx_byte cleared, timing registers at defaults.
`timescale 1ns / 1ps

`include "onewire_master_slot_engine_macros.svh"

module onewire_master_slot_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [7:0]                    tx_byte_i,
  input  logic                          line_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          drive_low_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic                          no_device_o,
  output logic [7:0]                    rx_byte_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [owm_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic             in_valid_q;
  logic [1:0]       cmd_q;
  logic [7:0]       tx_byte_q;
  logic             line_level_q;
  logic             out_valid_q;
  owm_pkg::result_t out_q;
  owm_pkg::result_t res;
  owm_pkg::cfg_t    cfg;
  logic             out_free;
  logic             step;

  // Pipeline control: the held item moves on when the output register is free.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  owm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .cmd_i        (cmd_q),
    .tx_byte_i    (tx_byte_q),
    .line_level_i (line_level_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // Input item register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q        <= cmd_i;
      tx_byte_q    <= tx_byte_i;
      line_level_q <= line_level_i;
    end
  end

  // Output item register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = out_q.drive_low;
  assign busy_res_o  = out_q.busy_res;
  assign done_res_o  = out_q.done_res;
  assign no_device_o = out_q.no_device;
  assign rx_byte_o   = out_q.rx_byte;

  // A completing tick leaves the sequencer idle.
  `OWM_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, out_valid_o && done_res_o, !busy_res_o)
  // The line is only driven in phases that continue after the tick.
  `OWM_ASSERT_NOW(a_drive_busy, clk_i, rst_ni, out_valid_o && drive_low_o, busy_res_o)
  // A held item is kept while the output side is stalled.
  `OWM_ASSERT_NEXT(a_hold_item, clk_i, rst_ni, in_valid_q && out_valid_q && !out_ready_i,
                   in_valid_q && out_valid_q)

endmodule

// ===== bench/tb_onewire_master_slot_engine.sv =====
// Self-checking testbench for the One-Wire master slot engine.
`timescale 1ns / 1ps

module tb_onewire_master_slot_engine;

  // How the bus level is generated while an operation runs.
  typedef enum logic [1:0] {
    LN_HIGH,
    LN_LOW,
    LN_RANDOM,
    LN_DEVICE
  } line_mode_e;

  // Timing set loaded before a row of the directed script.
  typedef enum logic [1:0] {
    PRE_KEEP,
    PRE_DEFAULT,
    PRE_SHORT
  } preset_e;

  // One row of the directed script: an item that opens an operation.
  typedef struct {
    preset_e          preset;
    owm_pkg::cmd_e    cmd;
    logic [7:0]       tx;
    line_mode_e       lmode;
    bit               lit;
    owm_pkg::result_t lit_res;
  } script_row_t;

  localparam owm_pkg::result_t QUIET_AFTER_RESET = '{drive_low: 1'b0, busy_res: 1'b0,
                                                      done_res: 1'b0, no_device: 1'b0,
                                                      rx_byte: 8'h00};
  localparam owm_pkg::result_t SLOT_OPEN_CLEAN = '{drive_low: 1'b1, busy_res: 1'b1,
                                                    done_res: 1'b0, no_device: 1'b0,
                                                    rx_byte: 8'h00};
  localparam owm_pkg::cfg_t DEFAULT_TIMING = '{owm_pkg::RESET_LOW_DEFAULT,
                                               owm_pkg::RESET_RELEASE_DEFAULT,
                                               owm_pkg::PRES_WAIT_DEFAULT,
                                               owm_pkg::PRES_LOW_DEFAULT,
                                               owm_pkg::ONE_LOW_DEFAULT,
                                               owm_pkg::ZERO_LOW_DEFAULT,
                                               owm_pkg::READ_LOW_DEFAULT,
                                               owm_pkg::READ_TAIL_DEFAULT};
  localparam int ScriptLen = 12;
  localparam int RandomPhases = 3;
  localparam int ItemTarget = 550;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [1:0]                    cmd_i;
  logic [7:0]                    tx_byte_i;
  logic                          line_level_i;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          drive_low_o;
  logic                          busy_res_o;
  logic                          done_res_o;
  logic                          no_device_o;
  logic [7:0]                    rx_byte_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [owm_pkg::AddrWidth-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  // Predicted sequencer state and timing registers.
  owm_pkg::cfg_t   timing;
  owm_pkg::phase_e seq_ph;
  logic [9:0]      seq_cnt;
  logic [2:0]      seq_bit;
  logic [7:0]      seq_shift;
  logic            seq_nodev;
  logic [7:0]      seq_rx;

  // Expected result items, oldest first.
  owm_pkg::result_t slot_results_q[$];

  // Simple bus device: holds the line high, then low for a presence pulse.
  line_mode_e line_mode;
  int         dev_cnt;
  int         dev_delay;
  int         dev_low;

  bit no_idle;
  int ready_hold = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int items_sent;

  // Directed script: every operation under the zero-duration timing set, with the
  // first items after reset checked against literal results.
  script_row_t script [ScriptLen] = '{
    '{PRE_KEEP,    owm_pkg::CMD_TICK,  8'h00, LN_RANDOM, 1'b1, QUIET_AFTER_RESET},
    '{PRE_SHORT,   owm_pkg::CMD_WRITE, 8'h80, LN_RANDOM, 1'b1, SLOT_OPEN_CLEAN},
    '{PRE_KEEP,    owm_pkg::CMD_WRITE, 8'h00, LN_RANDOM, 1'b1, SLOT_OPEN_CLEAN},
    '{PRE_KEEP,    owm_pkg::CMD_READ,  8'h00, LN_DEVICE, 1'b1, SLOT_OPEN_CLEAN},
    '{PRE_KEEP,    owm_pkg::CMD_TICK,  8'hA5, LN_RANDOM, 1'b0, '0},
    '{PRE_KEEP,    owm_pkg::CMD_RESET, 8'h00, LN_DEVICE, 1'b0, '0},
    '{PRE_KEEP,    owm_pkg::CMD_RESET, 8'h00, LN_HIGH,   1'b0, '0},
    '{PRE_KEEP,    owm_pkg::CMD_RESET, 8'h00, LN_LOW,    1'b0, '0},
    '{PRE_KEEP,    owm_pkg::CMD_WRITE, 8'h01, LN_RANDOM, 1'b0, '0},
    '{PRE_KEEP,    owm_pkg::CMD_READ,  8'h00, LN_LOW,    1'b0, '0},
    '{PRE_KEEP,    owm_pkg::CMD_READ,  8'hFF, LN_HIGH,   1'b0, '0},
    '{PRE_DEFAULT, owm_pkg::CMD_TICK,  8'h00, LN_RANDOM, 1'b0, '0}
  };

  onewire_master_slot_engine u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .tx_byte_i    (tx_byte_i),
    .line_level_i (line_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_low_o  (drive_low_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .no_device_o  (no_device_o),
    .rx_byte_o    (rx_byte_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 250 MHz clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string field, int got, int want);
    $display("Mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
             field, results_seen, got, want);
    mismatch_count++;
  endtask

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 12);
  endfunction

  // Counts one tick of a timed phase; true once len ticks have passed.
  function automatic bit count_ticks(logic [9:0] len);
    seq_cnt = seq_cnt + 10'd1;
    if (seq_cnt >= len) begin
      seq_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the predicted sequencer by one tick and returns the result item.
  function automatic owm_pkg::result_t predict_slot(owm_pkg::cmd_e c, logic [7:0] tx,
                                                    logic ln);
    owm_pkg::result_t r;
    logic             drv;
    logic             fin;
    drv = 1'b0;
    fin = 1'b0;
    // A command starts an operation only from idle; its tick is the first one.
    if (seq_ph == owm_pkg::PH_IDLE && c != owm_pkg::CMD_TICK) begin
      seq_cnt = '0;
      seq_bit = '0;
      case (c)
        owm_pkg::CMD_RESET: seq_ph = owm_pkg::PH_RST_LOW;
        owm_pkg::CMD_WRITE: begin
          seq_shift = tx;
          seq_ph = owm_pkg::PH_WR_LOW;
        end
        default: begin
          seq_shift = '0;
          seq_ph = owm_pkg::PH_RD_LOW;
        end
      endcase
    end
    case (seq_ph)
      owm_pkg::PH_RST_LOW: begin
        drv = 1'b1;
        if (count_ticks(timing.reset_low_time)) begin
          if (timing.reset_release_time == '0) begin
            seq_ph = owm_pkg::PH_PRES_WAIT;
          end else begin
            seq_ph = owm_pkg::PH_RST_REL;
          end
        end
      end
      owm_pkg::PH_RST_REL: begin
        if (count_ticks(10'(timing.reset_release_time))) begin
          seq_ph = owm_pkg::PH_PRES_WAIT;
        end
      end
      owm_pkg::PH_PRES_WAIT: begin
        // High ticks count toward the wait limit; the first low tick opens the pulse.
        if (ln) begin
          if (count_ticks(10'(timing.presence_wait_limit))) begin
            seq_nodev = 1'b1;
            fin = 1'b1;
          end
        end else if (timing.presence_low_limit <= 9'd1) begin
          seq_nodev = 1'b1;
          fin = 1'b1;
        end else begin
          seq_cnt = 10'd1;
          seq_ph = owm_pkg::PH_PRES_LOW;
        end
      end
      owm_pkg::PH_PRES_LOW: begin
        if (ln) begin
          seq_nodev = 1'b0;
          fin = 1'b1;
        end else if (count_ticks(10'(timing.presence_low_limit))) begin
          seq_nodev = 1'b1;
          fin = 1'b1;
        end
      end
      owm_pkg::PH_WR_LOW: begin
        drv = 1'b1;
        if (count_ticks(seq_shift[0] ? 10'(timing.one_low_time)
                                     : 10'(timing.zero_low_time))) begin
          seq_ph = owm_pkg::PH_WR_REC;
        end
      end
      owm_pkg::PH_WR_REC: begin
        if (count_ticks(seq_shift[0] ? owm_pkg::WR1_RECOVERY : owm_pkg::WR0_RECOVERY)) begin
          seq_shift = seq_shift >> 1;
          if (seq_bit == 3'd7) begin
            fin = 1'b1;
          end else begin
            seq_bit = seq_bit + 3'd1;
            seq_ph = owm_pkg::PH_WR_LOW;
          end
        end
      end
      owm_pkg::PH_RD_LOW: begin
        drv = 1'b1;
        if (count_ticks(10'(timing.read_low_time))) begin
          seq_ph = owm_pkg::PH_RD_SAMP;
        end
      end
      owm_pkg::PH_RD_SAMP: begin
        seq_shift = {ln, seq_shift[7:1]};
        seq_cnt = '0;
        seq_ph = owm_pkg::PH_RD_TAIL;
      end
      owm_pkg::PH_RD_TAIL: begin
        if (count_ticks(10'(timing.read_tail_time))) begin
          if (seq_bit == 3'd7) begin
            seq_rx = seq_shift;
            fin = 1'b1;
          end else begin
            seq_bit = seq_bit + 3'd1;
            seq_ph = owm_pkg::PH_RD_LOW;
          end
        end
      end
      default: begin
        seq_cnt = '0;
        seq_bit = '0;
      end
    endcase
    if (fin) begin
      seq_ph = owm_pkg::PH_IDLE;
      seq_cnt = '0;
      seq_bit = '0;
    end
    r.drive_low = drv;
    r.busy_res = (seq_ph != owm_pkg::PH_IDLE);
    r.done_res = fin;
    r.no_device = seq_nodev;
    r.rx_byte = seq_rx;
    return r;
  endfunction

  // Bus level for the next item, from the line mode and the predicted phase.
  function automatic logic pick_line();
    logic lvl;
    lvl = 1'($urandom_range(0, 1));
    case (line_mode)
      LN_HIGH: lvl = 1'b1;
      LN_LOW:  lvl = 1'b0;
      LN_DEVICE: begin
        if (seq_ph == owm_pkg::PH_PRES_WAIT || seq_ph == owm_pkg::PH_PRES_LOW) begin
          lvl = !(dev_cnt >= dev_delay && dev_cnt < dev_delay + dev_low);
          dev_cnt++;
        end
      end
      default: ;
    endcase
    return lvl;
  endfunction

  // Picks the line mode and presence pulse shape for the next operation.
  task automatic arm_line(line_mode_e m);
    int wait_eff;
    int low_eff;
    wait_eff = (timing.presence_wait_limit == '0) ? 1 : int'(timing.presence_wait_limit);
    low_eff = (timing.presence_low_limit == '0) ? 1 : int'(timing.presence_low_limit);
    line_mode = m;
    dev_cnt = 0;
    dev_delay = $urandom_range(0, wait_eff - 1);
    dev_low = $urandom_range(1, low_eff);
  endtask

  // Offers one tick item, waits for it to be taken and records its expected result.
  task automatic send_tick(owm_pkg::cmd_e c, logic [7:0] tx, logic ln, bit use_lit,
                           owm_pkg::result_t lit);
    int               gap;
    owm_pkg::result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    tx_byte_i <= tx;
    line_level_i <= ln;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_slot(c, tx, ln);
    slot_results_q.push_back(use_lit ? lit : pred);
    items_sent++;
  endtask

  // Opens an operation (or sends an idle tick) with the given line behavior.
  task automatic start_op(owm_pkg::cmd_e c, logic [7:0] tx, line_mode_e m, bit use_lit,
                          owm_pkg::result_t lit);
    arm_line(m);
    send_tick(c, tx, pick_line(), use_lit, lit);
  endtask

  // Runs the current operation to its end; some ticks carry commands that must be ignored.
  task automatic finish_op();
    owm_pkg::cmd_e c;
    while (seq_ph != owm_pkg::PH_IDLE) begin
      c = owm_pkg::CMD_TICK;
      if ($urandom_range(0, 99) < 15) begin
        c = owm_pkg::cmd_e'($urandom_range(0, 3));
      end
      send_tick(c, 8'($urandom), pick_line(), 1'b0, '0);
    end
  endtask

  // Brings the block to idle with every expected result delivered.
  task automatic drain();
    finish_op();
    in_valid_i <= 1'b0;
    while (slot_results_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One register write: setup phase, access phase, then the bus goes idle.
  task automatic write_reg(owm_pkg::reg_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      owm_pkg::REG_RESET_LOW:     timing.reset_low_time = val[9:0];
      owm_pkg::REG_RESET_RELEASE: timing.reset_release_time = val[7:0];
      owm_pkg::REG_PRES_WAIT:     timing.presence_wait_limit = val[7:0];
      owm_pkg::REG_PRES_LOW:      timing.presence_low_limit = val[8:0];
      owm_pkg::REG_ONE_LOW:       timing.one_low_time = val[3:0];
      owm_pkg::REG_ZERO_LOW:      timing.zero_low_time = val[6:0];
      owm_pkg::REG_READ_LOW:      timing.read_low_time = val[3:0];
      default:                    timing.read_tail_time = val[6:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_timing(owm_pkg::cfg_t c);
    write_reg(owm_pkg::REG_RESET_LOW, 32'(c.reset_low_time));
    write_reg(owm_pkg::REG_RESET_RELEASE, 32'(c.reset_release_time));
    write_reg(owm_pkg::REG_PRES_WAIT, 32'(c.presence_wait_limit));
    write_reg(owm_pkg::REG_PRES_LOW, 32'(c.presence_low_limit));
    write_reg(owm_pkg::REG_ONE_LOW, 32'(c.one_low_time));
    write_reg(owm_pkg::REG_ZERO_LOW, 32'(c.zero_low_time));
    write_reg(owm_pkg::REG_READ_LOW, 32'(c.read_low_time));
    write_reg(owm_pkg::REG_READ_TAIL, 32'(c.read_tail_time));
  endtask

  // Short timing so many operations fit; zeros act as one, a zero release is skipped.
  function automatic owm_pkg::cfg_t small_timing();
    owm_pkg::cfg_t c;
    c.reset_low_time = 10'($urandom_range(0, 10));
    c.reset_release_time = 8'($urandom_range(0, 4));
    c.presence_wait_limit = 8'($urandom_range(0, 8));
    c.presence_low_limit = 9'($urandom_range(0, 10));
    c.one_low_time = 4'($urandom_range(0, 15));
    c.zero_low_time = 7'($urandom_range(0, 6));
    c.read_low_time = 4'($urandom_range(0, 5));
    c.read_tail_time = 7'($urandom_range(0, 5));
    return c;
  endfunction

  function automatic owm_pkg::cfg_t preset_timing(preset_e p);
    case (p)
      PRE_SHORT: return '0;
      default:   return DEFAULT_TIMING;
    endcase
  endfunction

  function automatic owm_pkg::cmd_e pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return owm_pkg::CMD_TICK;
    if (r < 55) return owm_pkg::CMD_RESET;
    if (r < 70) return owm_pkg::CMD_WRITE;
    return owm_pkg::CMD_READ;
  endfunction

  function automatic line_mode_e pick_mode();
    if ($urandom_range(0, 99) < 80) begin
      return LN_DEVICE;
    end
    return line_mode_e'($urandom_range(0, 2));
  endfunction

  // Result checker and receiver back-pressure.
  always @(posedge clk_i) begin : result_check
    owm_pkg::result_t want;
    int               g;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (slot_results_q.size() == 0) begin
        report_mismatch("result with no item pending", 0, 0);
      end else begin
        want = slot_results_q.pop_front();
        if (drive_low_o !== want.drive_low) begin
          report_mismatch("drive_low", drive_low_o, want.drive_low);
        end
        if (busy_res_o !== want.busy_res) begin
          report_mismatch("busy_res", busy_res_o, want.busy_res);
        end
        if (done_res_o !== want.done_res) begin
          report_mismatch("done_res", done_res_o, want.done_res);
        end
        if (no_device_o !== want.no_device) begin
          report_mismatch("no_device", no_device_o, want.no_device);
        end
        if (rx_byte_o !== want.rx_byte) begin
          report_mismatch("rx_byte", rx_byte_o, want.rx_byte);
        end
      end
      results_seen++;
    end
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end else begin
      g = pick_gap();
      out_ready_i <= (g == 0);
      ready_hold = (g > 0) ? g - 1 : 0;
    end
  end

  // Main stimulus: reset, directed script, then random phases under several timing sets.
  initial begin : stimulus
    owm_pkg::cfg_t pick;
    int            budget_end;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    cmd_i <= owm_pkg::CMD_TICK;
    tx_byte_i <= 8'h00;
    line_level_i <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    timing = DEFAULT_TIMING;
    seq_ph = owm_pkg::PH_IDLE;
    seq_cnt = '0;
    seq_bit = '0;
    seq_shift = '0;
    seq_nodev = 1'b0;
    seq_rx = '0;
    line_mode = LN_RANDOM;
    no_idle = 1'b0;
    items_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script.
    foreach (script[i]) begin
      if (script[i].preset != PRE_KEEP) begin
        drain();
        load_timing(preset_timing(script[i].preset));
      end
      start_op(script[i].cmd, script[i].tx, script[i].lmode, script[i].lit,
               script[i].lit_res);
      finish_op();
    end

    // Random phases share what is left of the item budget; the middle one uses the
    // zero-duration timing set. Write bytes carry few ones, since a one bit costs a
    // long recovery.
    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      if (p == 1) begin
        pick = preset_timing(PRE_SHORT);
      end else begin
        pick = small_timing();
      end
      load_timing(pick);
      no_idle = ($urandom_range(0, 3) == 0);
      budget_end = items_sent + (ItemTarget - items_sent) / (RandomPhases - p);
      while (items_sent < budget_end) begin
        start_op(pick_cmd(), 8'($urandom & $urandom & $urandom), pick_mode(), 1'b0, '0);
        finish_op();
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin : watchdog
    #(1_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
